FILE: rtl/core/lkc_pkg.sv
// Shared types and constants for the LRU key cache.
package lkc_pkg;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [31:0] GEN_FIRST = 32'd1;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [63:0] key;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] generation;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } rsp_t;

  typedef struct packed {
    logic key;
    logic gen;
    logic rank;
  } store_we_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_INSERT = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

endpackage

FILE: rtl/core/lkc_store.sv
// Slot memories: key, generation and age rank, one read and one write port each.
module lkc_store #(
  parameter int ENTRIES = 16,
  parameter int AW      = 4
) (
  input  logic                    clk,
  input  logic [AW-1:0]           rd_addr,
  input  logic [AW-1:0]           wr_addr,
  input  lkc_pkg::store_we_t      we,
  input  logic [63:0]             wr_key,
  input  logic [31:0]             wr_gen,
  input  logic [AW-1:0]           wr_rank,
  output logic [63:0]             rd_key,
  output logic [31:0]             rd_gen,
  output logic [AW-1:0]           rd_rank
);
  import lkc_pkg::*;

  logic [63:0]   key_mem  [ENTRIES];
  logic [31:0]   gen_mem  [ENTRIES];
  logic [AW-1:0] rank_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we.key) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.gen) begin
      gen_mem[wr_addr] <= wr_gen;
    end
    rd_gen <= gen_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.rank) begin
      rank_mem[wr_addr] <= wr_rank;
    end
    rd_rank <= rank_mem[rd_addr];
  end

endmodule

FILE: rtl/core/lkc_ctrl.sv
// Sequencer and shared slot unit: walks the slots to match, age, evict and insert.
module lkc_ctrl #(
  parameter int ENTRIES = 16,
  parameter int AW      = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  lkc_pkg::req_t       req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output lkc_pkg::rsp_t       rsp,
  input  logic [AW:0]         cap,
  output logic [AW-1:0]       rd_addr,
  output logic [AW-1:0]       wr_addr,
  output lkc_pkg::store_we_t  we,
  output logic [63:0]         wr_key,
  output logic [31:0]         wr_gen,
  output logic [AW-1:0]       wr_rank,
  input  logic [63:0]         rd_key,
  input  logic [31:0]         rd_gen,
  input  logic [AW-1:0]       rd_rank
);
  import lkc_pkg::*;

  localparam int IW = AW + 1;

  state_t               state;
  logic [IW-1:0]        idx;
  logic                 live;
  logic [AW-1:0]        paddr;
  logic [ENTRIES-1:0]   valid;
  logic [63:0]          key_q;
  logic                 found;
  logic                 have_free;
  logic [AW-1:0]        fslot;
  logic [AW-1:0]        frank;
  logic [31:0]          fgen;
  logic [31:0]          hits_seen;
  logic [31:0]          misses_seen;
  logic [31:0]          next_gen;

  logic                 walk_end;
  logic                 slot_v;
  logic                 match;
  logic [IW-1:0]        rank_inc;
  logic                 evict;
  logic                 older;
  logic                 rsp_load;

  assign req_ready = (state == ST_IDLE);
  assign walk_end  = (idx == IW'(ENTRIES));
  assign rd_addr   = walk_end ? '0 : idx[AW-1:0];
  assign slot_v    = valid[paddr];
  assign match     = live && slot_v && (rd_key == key_q);
  assign rank_inc  = {1'b0, rd_rank} + IW'(1);
  // a miss keeps only ranks below cap-1; a zero cap drops everything
  assign evict     = !found && (rank_inc >= cap);
  assign older     = (rd_rank < frank);
  assign rsp_load  = (state == ST_RESULT) && (!rsp_valid || rsp_ready);

  always_comb begin
    we      = '0;
    wr_addr = paddr;
    wr_key  = key_q;
    wr_gen  = next_gen;
    wr_rank = '0;
    if (state == ST_UPDATE && live && slot_v) begin
      if (found) begin
        if (paddr == fslot) begin
          we.rank = 1'b1;
        end else if (older) begin
          we.rank = 1'b1;
          wr_rank = rank_inc[AW-1:0];
        end
      end else if (!evict) begin
        we.rank = 1'b1;
        wr_rank = rank_inc[AW-1:0];
      end
    end
    if (state == ST_INSERT) begin
      we      = '{key: 1'b1, gen: 1'b1, rank: 1'b1};
      wr_addr = fslot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      valid       <= '0;
      hits_seen   <= '0;
      misses_seen <= '0;
      next_gen    <= GEN_FIRST;
      rsp_valid   <= 1'b0;
      live        <= 1'b0;
      idx         <= '0;
      found       <= 1'b0;
      have_free   <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            key_q     <= req.key;
            idx       <= '0;
            live      <= 1'b0;
            found     <= 1'b0;
            have_free <= 1'b0;
            if (req.command == CMD_CLEAR) begin
              valid       <= '0;
              hits_seen   <= '0;
              misses_seen <= '0;
              next_gen    <= GEN_FIRST;
              fgen        <= '0;
              state       <= ST_RESULT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (match) begin
            found <= 1'b1;
            fslot <= paddr;
            frank <= rd_rank;
            fgen  <= rd_gen;
          end
          if (walk_end) begin
            idx   <= '0;
            live  <= 1'b0;
            state <= ST_UPDATE;
          end else begin
            idx   <= idx + IW'(1);
            live  <= 1'b1;
            paddr <= idx[AW-1:0];
          end
        end
        ST_UPDATE: begin
          if (live && slot_v && evict) begin
            valid[paddr] <= 1'b0;
          end
          // remember the lowest slot that is empty once this walk is done
          if (live && !found && !have_free && (!slot_v || evict)) begin
            have_free <= 1'b1;
            fslot     <= paddr;
          end
          if (walk_end) begin
            idx  <= '0;
            live <= 1'b0;
            if (found) begin
              hits_seen <= hits_seen + 32'd1;
              state     <= ST_RESULT;
            end else begin
              state <= ST_INSERT;
            end
          end else begin
            idx   <= idx + IW'(1);
            live  <= 1'b1;
            paddr <= idx[AW-1:0];
          end
        end
        ST_INSERT: begin
          valid[fslot] <= 1'b1;
          misses_seen  <= misses_seen + 32'd1;
          next_gen     <= next_gen + 32'd1;
          fgen         <= next_gen;
          state        <= ST_RESULT;
        end
        ST_RESULT: begin
          // hold until the output register is free
          if (rsp_load) begin
            rsp   <= '{hit: found, generation: fgen,
                       hit_total: hits_seen, miss_total: misses_seen};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/lru_key_cache.sv
// LRU key cache top level: capacity register, sequencer and slot memories.
//
// Request beats (req_valid/req_ready) carry a command and a 64-bit key.
// A lookup either finds the key (hit, returns its generation, makes it most
// recent) or misses, evicts least-recent entries down to below the
// capacity and inserts the key with the next generation. A clear command
// empties the cache and zeroes the counters. Every request gives exactly
// one response beat (rsp_valid/rsp_ready) with the running hit and miss
// totals. The capacity register is written through cap_we/cap_data;
// the user must write it only while the block is idle, which the block
// does not enforce; values above ENTRIES act as ENTRIES. One slot unit
// walks all ENTRIES slots twice per lookup, one slot per cycle through
// the registered memory read: scan walk, update walk, insert on a miss.
// The response appears in the same cycle that the block is ready again.
// The response sits in an output register; if the receiver stalls, the
// finished result waits there and the next request is still taken, but a
// second result holds the sequencer until the first beat leaves.
// Reset empties the cache, zeroes the counters, sets the next generation
// to 1 and the capacity to 16; no clearing pass is needed.
module lru_key_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  lkc_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output lkc_pkg::rsp_t                   rsp,
  input  logic                            cap_we,
  input  logic [lkc_pkg::CAP_W-1:0]       cap_data
);
  import lkc_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]    cap_wide;
  logic [CW-1:0]    cap_sat;
  logic [AW:0]      cap_lim;

  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  store_we_t        we;
  logic [63:0]      wr_key;
  logic [31:0]      wr_gen;
  logic [AW-1:0]    wr_rank;
  logic [63:0]      rd_key;
  logic [31:0]      rd_gen;
  logic [AW-1:0]    rd_rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cap_we) begin
      capacity <= cap_data;
    end
  end

  assign cap_wide = CW'(capacity);
  assign cap_sat  = (cap_wide > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_wide;
  assign cap_lim  = cap_sat[AW:0];

  lkc_ctrl #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cap       (cap_lim),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .we        (we),
    .wr_key    (wr_key),
    .wr_gen    (wr_gen),
    .wr_rank   (wr_rank),
    .rd_key    (rd_key),
    .rd_gen    (rd_gen),
    .rd_rank   (rd_rank)
  );

  lkc_store #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .we      (we),
    .wr_key  (wr_key),
    .wr_gen  (wr_gen),
    .wr_rank (wr_rank),
    .rd_key  (rd_key),
    .rd_gen  (rd_gen),
    .rd_rank (rd_rank)
  );

  // an accepted request always keeps the sequencer busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one still in work");

  // a fresh response beat only comes out of a busy sequencer
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("response produced without work");

  // a clear response is all zero
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.command == CMD_CLEAR) ##1 !rsp_valid || rsp_ready
    |=> rsp_valid && !rsp.hit && (rsp.generation == 32'd0) && (rsp.hit_total == 32'd0)
        && (rsp.miss_total == 32'd0))
    else $error("clear response not zero");

endmodule

FILE: tb/sv/lru_key_cache_tb.sv
// Self-checking testbench for the LRU key cache: directed and random lookups checked beat by beat.
module lru_key_cache_tb;
  import lkc_pkg::*;

  localparam int SLOTS          = 16;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 165;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_PRINTS     = 50;

  logic             clk;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req       = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cap_we    = 1'b0;
  logic [CAP_W-1:0] cap_data  = CAP_RESET;

  // Mirror of the cache contents and counters.
  logic [63:0]      tag_key   [SLOTS];
  logic             tag_valid [SLOTS] = '{default: 1'b0};
  logic [31:0]      tag_gen   [SLOTS];
  logic [3:0]       tag_rank  [SLOTS];
  logic [31:0]      hit_cnt   = '0;
  logic [31:0]      miss_cnt  = '0;
  logic [31:0]      gen_next  = GEN_FIRST;
  logic [CAP_W-1:0] cache_cap = CAP_RESET;

  req_t cache_reqs[$];
  rsp_t cache_answers[$];

  int err_count      = 0;
  int quiet_cycles   = 0;
  int reqs_driven    = 0;
  int reqs_taken     = 0;
  int send_gap_pct   = 10;
  int recv_stall_pct = 60;

  lru_key_cache #(
    .ENTRIES(SLOTS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cap_we    (cap_we),
    .cap_data  (cap_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Apply one request to the mirror and return the answer it must produce.
  function automatic rsp_t cache_lookup(input req_t r);
    rsp_t       res;
    int         hit_slot;
    int         slot;
    int         cap_eff;
    int         fill;
    logic [3:0] rank;
    res = '0;
    if (r.command == CMD_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) tag_valid[i] = 1'b0;
      hit_cnt  = '0;
      miss_cnt = '0;
      gen_next = GEN_FIRST;
      return res;
    end
    hit_slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (hit_slot < 0 && tag_valid[i] && tag_key[i] == r.key) hit_slot = i;
    if (hit_slot >= 0) begin
      hit_cnt = hit_cnt + 32'd1;
      rank = tag_rank[hit_slot];
      for (int i = 0; i < SLOTS; i++)
        if (tag_valid[i] && tag_rank[i] < rank) tag_rank[i] = tag_rank[i] + 4'd1;
      tag_rank[hit_slot] = '0;
      res.hit        = 1'b1;
      res.generation = tag_gen[hit_slot];
      res.hit_total  = hit_cnt;
      res.miss_total = miss_cnt;
      return res;
    end
    miss_cnt = miss_cnt + 32'd1;
    cap_eff = (cache_cap > SLOTS) ? SLOTS : int'(cache_cap);
    if (cap_eff == 0) begin
      for (int i = 0; i < SLOTS; i++) tag_valid[i] = 1'b0;
    end else begin
      fill = 0;
      for (int i = 0; i < SLOTS; i++) if (tag_valid[i]) fill++;
      // drop the least recent entry until there is room
      while (fill >= cap_eff) begin
        for (int i = 0; i < SLOTS; i++)
          if (tag_valid[i] && tag_rank[i] == fill - 1) tag_valid[i] = 1'b0;
        fill--;
      end
    end
    slot = -1;
    for (int i = 0; i < SLOTS; i++) if (slot < 0 && !tag_valid[i]) slot = i;
    for (int i = 0; i < SLOTS; i++) if (tag_valid[i]) tag_rank[i] = tag_rank[i] + 4'd1;
    tag_valid[slot] = 1'b1;
    tag_key[slot]   = r.key;
    tag_gen[slot]   = gen_next;
    tag_rank[slot]  = '0;
    gen_next        = gen_next + 32'd1;
    res.generation  = tag_gen[slot];
    res.hit_total   = hit_cnt;
    res.miss_total  = miss_cnt;
    return res;
  endfunction

  task automatic report_error(input string msg);
    if (err_count < MAX_PRINTS) $display("%0t ERROR: %s", $time, msg);
    err_count++;
  endtask

  task automatic push_item(input logic cmd, input logic [63:0] key);
    req_t r;
    r.command = cmd;
    r.key     = key;
    cache_reqs = {cache_reqs, r};
  endtask

  // Hold until every queued request is taken and every answer has come back.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (cache_reqs.size() != 0 || req_valid || cache_answers.size() != 0);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cap_we    <= 1'b1;
    cap_data  <= value;
    cache_cap = value;
    @(negedge clk);
    cap_we <= 1'b0;
  endtask

  // Request driver: advance to the next beat only after the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || reqs_driven == reqs_taken) begin
      if (cache_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        req       <= cache_reqs[0];
        req_valid <= 1'b1;
        cache_reqs.delete(0);
        reqs_driven++;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Monitor: check answers in order, predict on every accepted request.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (cache_answers.size() == 0) begin
          report_error("response beat with nothing outstanding");
        end else begin
          want = cache_answers[0];
          cache_answers.delete(0);
          if (rsp.hit !== want.hit)
            report_error($sformatf("hit got %0d want %0d", rsp.hit, want.hit));
          if (rsp.generation !== want.generation)
            report_error($sformatf("generation got %0d want %0d",
                                   rsp.generation, want.generation));
          if (rsp.hit_total !== want.hit_total)
            report_error($sformatf("hit_total got %0d want %0d",
                                   rsp.hit_total, want.hit_total));
          if (rsp.miss_total !== want.miss_total)
            report_error($sformatf("miss_total got %0d want %0d",
                                   rsp.miss_total, want.miss_total));
        end
      end
      if (req_valid && req_ready) begin
        cache_answers = {cache_answers, cache_lookup(req)};
        reqs_taken++;
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] pool [$];
    logic [63:0] k;
    int          caps [PHASES];
    int          eff;
    int          pick;
    caps = '{31, 16, 2, 5, 0, 8, 1, 12, 17, 3};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset capacity: extremes of the key, hits, and a clear that ignores its key.
    push_item(CMD_LOOKUP, 64'h0);
    push_item(CMD_LOOKUP, '1);
    push_item(CMD_LOOKUP, 64'h0);
    push_item(CMD_LOOKUP, '1);
    push_item(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
    push_item(CMD_LOOKUP, 64'h5555_5555_5555_5555);
    push_item(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
    push_item(CMD_CLEAR, '1);
    push_item(CMD_LOOKUP, '1);
    push_item(CMD_LOOKUP, '1);

    // Zero capacity still keeps the one entry just inserted.
    set_capacity(5'd0);
    push_item(CMD_LOOKUP, 64'd1);
    push_item(CMD_LOOKUP, 64'd1);
    push_item(CMD_LOOKUP, 64'd2);
    push_item(CMD_LOOKUP, 64'd1);

    set_capacity(5'd1);
    push_item(CMD_LOOKUP, 64'd3);
    push_item(CMD_LOOKUP, 64'd3);
    push_item(CMD_LOOKUP, 64'd4);
    push_item(CMD_LOOKUP, 64'd3);

    // Random phases; the cap-2 phase follows a full table without a clear.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_gap_pct   = 60;
        recv_stall_pct = 10;
      end else if (p == 6) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      set_capacity(caps[p][CAP_W-1:0]);
      eff = (caps[p] > SLOTS) ? SLOTS : caps[p];
      pool.delete();
      repeat (eff + $urandom_range(1, 6)) begin
        k = {$urandom, $urandom};
        pool = {pool, k};
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        k = pool[$urandom_range(pool.size() - 1)];
        // keep clears out of the tail so the table is filled at the phase change
        if (pick < 2 && n < PHASE_ITEMS - 20) push_item(CMD_CLEAR, {$urandom, $urandom});
        else if (pick < 10) push_item(CMD_LOOKUP, {$urandom, $urandom});
        else if (pick < 15) push_item(CMD_LOOKUP, k ^ (64'd1 << $urandom_range(63)));
        else push_item(CMD_LOOKUP, k);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (cache_answers.size() != 0)
      report_error($sformatf("%0d answers never arrived", cache_answers.size()));
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
